// File: hw/rtl/robh_pkg.sv
// Package for the ray against oriented box hit unit: fixed-point types, register
// indexes, saturation and rounding helpers and the restoring divider step.
// Depends on nothing; every RTL file of the unit imports it.
`timescale 1ns / 1ps
`default_nettype none

package robh_pkg;

    // Coordinates are signed Q16.16, quaternion parts signed Q2.30.
    typedef logic signed [31:0] t_q16;
    typedef logic signed [63:0] t_prod;

    typedef enum logic [2:0] {
        CFG_X_FACE    = 3'd0,
        CFG_Y_FACE    = 3'd1,
        CFG_Z_FACE    = 3'd2,
        CFG_CENTER_XY = 3'd3,
        CFG_CENTER_Z  = 3'd4,
        CFG_ROT_WX    = 3'd5,
        CFG_ROT_YZ    = 3'd6
    } t_cfg_idx;

    localparam logic [63:0] ROT_WX_RESET = 64'h4000_0000_0000_0000;

    // Quotient bits of the clipping divider; the quotient is capped at 2^40.
    localparam int unsigned QUO_W     = 41;
    localparam int unsigned DIV_STEPS = QUO_W;
    localparam logic [QUO_W-1:0] QUO_CAP = {1'b1, {(QUO_W-1){1'b0}}};

    // Registers from the input capture to the output register, inclusive.
    localparam int unsigned PIPE_DEPTH = 13 + DIV_STEPS;

    localparam logic signed [65:0] MAX32 = 66'sd2147483647;
    localparam logic signed [65:0] MIN32 = -66'sd2147483648;
    localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

    // One lane of the divider: partial remainder, and the numerator bits still
    // to be consumed with the quotient bits shifting in behind them.
    typedef struct packed {
        logic [31:0]      rem;
        logic [QUO_W-1:0] nq;
        logic             ovf;
    } t_div_lane;

    // Per-axis data that travels alongside the divider lanes.
    typedef struct packed {
        logic [2:0]        cand;
        logic [2:0][31:0]  plane;
        logic [2:0][32:0]  mdiff;
        logic [2:0][31:0]  md;
        logic [2:0][31:0]  lo;
        logic [2:0]        ldneg;
    } t_side;

    function automatic t_q16 sat32(input logic signed [65:0] v);
        if (v > MAX32) begin
            return 32'sh7fff_ffff;
        end else if (v < MIN32) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Sum of three Q2.30 by Q16.16 products, rounded back to Q16.16.
    function automatic t_q16 mac_round(input t_prod a, input t_prod b, input t_prod c);
        logic signed [65:0] s;
        s = 66'(a) + 66'(b) + 66'(c) + (66'sd1 <<< 29);
        return sat32(s >>> 30);
    endfunction

    function automatic t_prod quat_term(input t_q16 a, input t_q16 b);
        t_prod p;
        p = 64'(a) * 64'(b);
        return p >>> 29;
    endfunction

    function automatic t_q16 clamp_one(input t_prod v);
        if (v > ONE_Q30) begin
            return 32'sh4000_0000;
        end else if (v < -ONE_Q30) begin
            return 32'shc000_0000;
        end
        return v[31:0];
    endfunction

    // Divisor axis of a divider lane; each axis owns two lanes.
    function automatic logic [1:0] lane_axis(input logic [2:0] l);
        case (l)
            3'd0, 3'd1: lane_axis = 2'd0;
            3'd2, 3'd3: lane_axis = 2'd1;
            default:    lane_axis = 2'd2;
        endcase
    endfunction

    // Coordinate that a divider lane produces: the next and the one after.
    function automatic logic [1:0] lane_other(input logic [2:0] l);
        case (l)
            3'd0:       lane_other = 2'd1;
            3'd1, 3'd2: lane_other = 2'd2;
            3'd3, 3'd4: lane_other = 2'd0;
            default:    lane_other = 2'd1;
        endcase
    endfunction

    function automatic t_div_lane div_init(input logic [63:0] num, input logic [31:0] dv);
        t_div_lane y;
        y.rem = {9'd0, num[63:QUO_W]};
        y.nq  = num[QUO_W-1:0];
        y.ovf = ({9'd0, num[63:QUO_W]} >= dv);
        return y;
    endfunction

    function automatic t_div_lane div_step(input t_div_lane x, input logic [31:0] dv);
        t_div_lane y;
        logic [32:0] t;
        t     = {x.rem, x.nq[QUO_W-1]};
        y.ovf = x.ovf;
        if (t >= {1'b0, dv}) begin
            y.rem = 32'(t - {1'b0, dv});
            y.nq  = {x.nq[QUO_W-2:0], 1'b1};
        end else begin
            y.rem = t[31:0];
            y.nq  = {x.nq[QUO_W-2:0], 1'b0};
        end
        return y;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ray_oriented_box_hit_unit.sv
// Top level of the ray against oriented box hit unit: configuration registers,
// the rotation matrix and the whole fixed pipeline. Depends on robh_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The unit tests one ray per clock against an oriented box and returns the
// nearest entry point in world coordinates. A ray is taken at a rising edge
// where start is high and busy is low; busy is low at all times except during
// reset and the cycle after it, so rays may be issued back to back. Every ray gives
// exactly one result beat on o_strobe, in issue order; the receiver cannot
// stall the unit and must take each beat as it comes. The pipeline depth
// is set by the clipping divider, which resolves one of 41 quotient bits
// per pipeline stage, plus thirteen stages of rotation,
// face selection and back-rotation. Configuration beats are taken whenever
// o_cfg_ready is high, but they must only be written while no ray is in
// flight; a ray may follow a configuration beat in the next cycle, because the
// rotation matrix derived from the quaternion is ready in the cycle after it is
// written. Indexes beyond the last register are ignored.
module ray_oriented_box_hit_unit
    import robh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_orig_x,
    input  wire logic [31:0] i_orig_y,
    input  wire logic [31:0] i_orig_z,
    input  wire logic [31:0] i_dir_x,
    input  wire logic [31:0] i_dir_y,
    input  wire logic [31:0] i_dir_z,

    output logic             o_strobe,
    output logic             o_hit,
    output logic [31:0]      o_hit_x,
    output logic [31:0]      o_hit_y,
    output logic [31:0]      o_hit_z,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        r_busy;
    logic [63:0] r_x_face, r_y_face, r_z_face, r_center_xy, r_rot_wx, r_rot_yz;
    logic [31:0] r_center_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b1;
            r_x_face    <= '0;
            r_y_face    <= '0;
            r_z_face    <= '0;
            r_center_xy <= '0;
            r_center_z  <= '0;
            r_rot_wx    <= ROT_WX_RESET;
            r_rot_yz    <= '0;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_X_FACE:    r_x_face    <= i_cfg_data;
                    CFG_Y_FACE:    r_y_face    <= i_cfg_data;
                    CFG_Z_FACE:    r_z_face    <= i_cfg_data;
                    CFG_CENTER_XY: r_center_xy <= i_cfg_data;
                    CFG_CENTER_Z:  r_center_z  <= i_cfg_data[31:0];
                    CFG_ROT_WX:    r_rot_wx    <= i_cfg_data;
                    CFG_ROT_YZ:    r_rot_yz    <= i_cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    // Box geometry in per-axis form.
    t_q16 face_pos [3];
    t_q16 face_neg [3];
    t_q16 center   [3];

    assign face_pos[0] = r_x_face[63:32];
    assign face_neg[0] = r_x_face[31:0];
    assign face_pos[1] = r_y_face[63:32];
    assign face_neg[1] = r_y_face[31:0];
    assign face_pos[2] = r_z_face[63:32];
    assign face_neg[2] = r_z_face[31:0];
    assign center[0]   = r_center_xy[63:32];
    assign center[1]   = r_center_xy[31:0];
    assign center[2]   = r_center_z;

    // ------------------------------------------------------------------
    // Rotation matrix, rebuilt from the quaternion every cycle. Each entry
    // is clamped to plus or minus one, so a non-unit quaternion is tolerated.
    // ------------------------------------------------------------------
    t_q16 n_m [3][3];
    t_q16 r_m [3][3];

    always_comb begin
        t_q16  qw, qx, qy, qz;
        t_prod t_xx, t_yy, t_zz, t_xy, t_xz, t_yz, t_wx, t_wy, t_wz;
        qw   = r_rot_wx[63:32];
        qx   = r_rot_wx[31:0];
        qy   = r_rot_yz[63:32];
        qz   = r_rot_yz[31:0];
        t_xx = quat_term(qx, qx);
        t_yy = quat_term(qy, qy);
        t_zz = quat_term(qz, qz);
        t_xy = quat_term(qx, qy);
        t_xz = quat_term(qx, qz);
        t_yz = quat_term(qy, qz);
        t_wx = quat_term(qw, qx);
        t_wy = quat_term(qw, qy);
        t_wz = quat_term(qw, qz);
        n_m[0][0] = clamp_one(ONE_Q30 - t_yy - t_zz);
        n_m[0][1] = clamp_one(t_xy - t_wz);
        n_m[0][2] = clamp_one(t_xz + t_wy);
        n_m[1][0] = clamp_one(t_xy + t_wz);
        n_m[1][1] = clamp_one(ONE_Q30 - t_xx - t_zz);
        n_m[1][2] = clamp_one(t_yz - t_wx);
        n_m[2][0] = clamp_one(t_xz - t_wy);
        n_m[2][1] = clamp_one(t_yz + t_wx);
        n_m[2][2] = clamp_one(ONE_Q30 - t_xx - t_yy);
    end

    always_ff @(posedge i_clk) begin
        r_m <= n_m;
    end

    // ------------------------------------------------------------------
    // Valid bits travel down a shift line beside the payload. The payload
    // registers load every cycle; only the valid bits carry meaning.
    // ------------------------------------------------------------------
    logic r_vld [PIPE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < PIPE_DEPTH; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[0] <= start && !r_busy;
            for (int s = 1; s < PIPE_DEPTH; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Front end: capture, centre removal, inverse rotation into box frame.
    // ------------------------------------------------------------------
    t_q16  r_s0_o [3], r_s0_d [3];
    t_q16  r_s1_o [3], r_s1_d [3];
    t_prod r_s2_po [3][3], r_s2_pd [3][3];
    t_q16  r_s3_lo [3], r_s3_ld [3];

    always_ff @(posedge i_clk) begin
        r_s0_o[0] <= i_orig_x;
        r_s0_o[1] <= i_orig_y;
        r_s0_o[2] <= i_orig_z;
        r_s0_d[0] <= i_dir_x;
        r_s0_d[1] <= i_dir_y;
        r_s0_d[2] <= i_dir_z;
        for (int i = 0; i < 3; i++) begin
            r_s1_o[i] <= sat32(66'(r_s0_o[i]) - 66'(center[i]));
            r_s1_d[i] <= r_s0_d[i];
        end
        // The inverse rotation uses the transposed matrix.
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_s2_po[i][j] <= 64'(r_m[j][i]) * 64'(r_s1_o[j]);
                r_s2_pd[i][j] <= 64'(r_m[j][i]) * 64'(r_s1_d[j]);
            end
        end
        for (int i = 0; i < 3; i++) begin
            r_s3_lo[i] <= mac_round(r_s2_po[i][0], r_s2_po[i][1], r_s2_po[i][2]);
            r_s3_ld[i] <= mac_round(r_s2_pd[i][0], r_s2_pd[i][1], r_s2_pd[i][2]);
        end
    end

    // ------------------------------------------------------------------
    // Face choice per axis. Only the face the origin lies strictly outside,
    // with the ray heading toward it, is a candidate.
    // ------------------------------------------------------------------
    t_side       n_s4_side;
    logic [31:0] n_s4_ald [3];
    t_side       r_s4_side;
    logic [31:0] r_s4_ald [3];

    always_comb begin
        logic signed [32:0] diff;
        t_q16               plane;
        n_s4_side = '0;
        for (int a = 0; a < 3; a++) begin
            plane = face_neg[a];
            n_s4_side.cand[a] = 1'b0;
            if (r_s3_ld[a] < 0 && r_s3_lo[a] > face_pos[a]) begin
                plane = face_pos[a];
                n_s4_side.cand[a] = 1'b1;
            end else if (r_s3_ld[a] > 0 && r_s3_lo[a] < face_neg[a]) begin
                n_s4_side.cand[a] = 1'b1;
            end
            diff = 33'(plane) - 33'(r_s3_lo[a]);
            n_s4_side.plane[a] = plane;
            n_s4_side.mdiff[a] = (diff < 0) ? 33'(-diff) : 33'(diff);
            n_s4_side.md[a]    = (r_s3_ld[a] < 0) ? 32'(-33'(r_s3_ld[a]))
                                                  : 32'(r_s3_ld[a]);
            n_s4_side.lo[a]    = r_s3_lo[a];
            n_s4_side.ldneg[a] = r_s3_ld[a][31];
            n_s4_ald[a]        = n_s4_side.md[a];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_side <= n_s4_side;
        r_s4_ald  <= n_s4_ald;
    end

    // ------------------------------------------------------------------
    // Divider numerators, with half the divisor added for rounding to
    // nearest, then the restoring divider: one quotient bit per stage.
    // ------------------------------------------------------------------
    logic [63:0] r_s5_num [6];
    t_side       r_s5_side;
    t_div_lane   r_div    [DIV_STEPS+1][6];
    t_side       r_dside  [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 6; l++) begin
            r_s5_num[l] <= 64'(r_s4_side.mdiff[lane_axis(3'(l))])
                           * 64'(r_s4_ald[lane_other(3'(l))])
                           + 64'(r_s4_side.md[lane_axis(3'(l))] >> 1);
        end
        r_s5_side <= r_s4_side;

        for (int l = 0; l < 6; l++) begin
            r_div[0][l] <= div_init(r_s5_num[l], r_s5_side.md[lane_axis(3'(l))]);
        end
        r_dside[0] <= r_s5_side;

        for (int s = 1; s <= DIV_STEPS; s++) begin
            for (int l = 0; l < 6; l++) begin
                r_div[s][l] <= div_step(r_div[s-1][l],
                                        r_dside[s-1].md[lane_axis(3'(l))]);
            end
            r_dside[s] <= r_dside[s-1];
        end
    end

    // ------------------------------------------------------------------
    // Clipped points and the face test. The test sees the unsaturated
    // coordinate; the stored point is saturated.
    // ------------------------------------------------------------------
    logic        n_pt_ok [3];
    t_q16        n_pt    [3][3];
    logic        r_pt_ok [3];
    t_q16        r_pt    [3][3];
    logic [32:0] r_pt_mdiff [3];
    logic [31:0] r_pt_md    [3];

    always_comb begin
        t_div_lane          ln;
        logic [QUO_W-1:0]   q;
        logic signed [42:0] v;
        logic [1:0]         a, b;
        t_side              sd;
        sd = r_dside[DIV_STEPS];
        for (int i = 0; i < 3; i++) begin
            n_pt_ok[i]    = sd.cand[i];
            n_pt[i][i]    = sd.plane[i];
        end
        for (int l = 0; l < 6; l++) begin
            ln = r_div[DIV_STEPS][l];
            a  = lane_axis(3'(l));
            b  = lane_other(3'(l));
            q  = (ln.ovf || ln.nq > QUO_CAP) ? QUO_CAP : ln.nq;
            if (sd.ldneg[b]) begin
                v = 43'($signed(sd.lo[b])) - $signed({2'b00, q});
            end else begin
                v = 43'($signed(sd.lo[b])) + $signed({2'b00, q});
            end
            if (v < 43'(face_neg[b]) || v > 43'(face_pos[b])) begin
                n_pt_ok[a] = 1'b0;
            end
            n_pt[a][b] = sat32(66'(v));
        end
    end

    always_ff @(posedge i_clk) begin
        r_pt_ok <= n_pt_ok;
        r_pt    <= n_pt;
        for (int i = 0; i < 3; i++) begin
            r_pt_mdiff[i] <= r_dside[DIV_STEPS].mdiff[i];
            r_pt_md[i]    <= r_dside[DIV_STEPS].md[i];
        end
    end

    // ------------------------------------------------------------------
    // Distance along the ray is mdiff / md; candidates are compared by
    // cross-multiplying. Ties keep the earlier axis.
    // ------------------------------------------------------------------
    logic [64:0] r_x_prod [6];
    logic        r_x_ok   [3];
    t_q16        r_x_pt   [3][3];

    always_ff @(posedge i_clk) begin
        r_x_prod[0] <= 65'(r_pt_mdiff[1]) * 65'(r_pt_md[0]);
        r_x_prod[1] <= 65'(r_pt_mdiff[0]) * 65'(r_pt_md[1]);
        r_x_prod[2] <= 65'(r_pt_mdiff[2]) * 65'(r_pt_md[0]);
        r_x_prod[3] <= 65'(r_pt_mdiff[0]) * 65'(r_pt_md[2]);
        r_x_prod[4] <= 65'(r_pt_mdiff[2]) * 65'(r_pt_md[1]);
        r_x_prod[5] <= 65'(r_pt_mdiff[1]) * 65'(r_pt_md[2]);
        r_x_ok      <= r_pt_ok;
        r_x_pt      <= r_pt;
    end

    logic n_sel_found;
    t_q16 n_sel_best [3];
    logic r_sel_found;
    t_q16 r_sel_best [3];

    always_comb begin
        logic       lt_yx, lt_zx, lt_zy, z_wins;
        logic [1:0] sel;
        lt_yx       = r_x_prod[0] < r_x_prod[1];
        lt_zx       = r_x_prod[2] < r_x_prod[3];
        lt_zy       = r_x_prod[4] < r_x_prod[5];
        sel         = 2'd0;
        n_sel_found = r_x_ok[0];
        if (r_x_ok[1] && (!n_sel_found || lt_yx)) begin
            sel         = 2'd1;
            n_sel_found = 1'b1;
        end
        z_wins = (sel == 2'd0) ? lt_zx : lt_zy;
        if (r_x_ok[2] && (!n_sel_found || z_wins)) begin
            sel         = 2'd2;
            n_sel_found = 1'b1;
        end
        for (int i = 0; i < 3; i++) begin
            n_sel_best[i] = r_x_pt[sel][i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel_found <= n_sel_found;
        r_sel_best  <= n_sel_best;
    end

    // ------------------------------------------------------------------
    // Back to world coordinates: forward rotation, then the centre.
    // ------------------------------------------------------------------
    t_prod r_w_prod [3][3];
    logic  r_w_found;
    t_q16  r_ws_world [3];
    logic  r_ws_found;
    logic  r_hit;
    t_q16  r_hit_pt [3];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_w_prod[i][j] <= 64'(r_m[i][j]) * 64'(r_sel_best[j]);
            end
        end
        r_w_found <= r_sel_found;

        for (int i = 0; i < 3; i++) begin
            r_ws_world[i] <= mac_round(r_w_prod[i][0], r_w_prod[i][1], r_w_prod[i][2]);
        end
        r_ws_found <= r_w_found;

        // A miss reports a zero point.
        r_hit <= r_ws_found;
        for (int i = 0; i < 3; i++) begin
            r_hit_pt[i] <= r_ws_found ? sat32(66'(r_ws_world[i]) + 66'(center[i]))
                                      : '0;
        end
    end

    assign o_strobe = r_vld[PIPE_DEPTH-1];
    assign o_hit    = r_hit;
    assign o_hit_x  = r_hit_pt[0];
    assign o_hit_y  = r_hit_pt[1];
    assign o_hit_z  = r_hit_pt[2];

endmodule

`default_nettype wire
